FILE: rtl/core/ouc_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 offset converter.
// Used by every module of the converter; depends on nothing else.
`timescale 1ns / 1ps

package ouc_pkg;

    localparam int FIELD_BITS  = 20;
    localparam int CP_BITS     = 21;
    localparam int S_TDATA_W   = 32;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 24;
    localparam int M_TUSER_W   = 1;

    localparam logic OPC_UNITS_TO_BYTES = 1'b0;
    localparam logic OPC_BYTES_TO_UNITS = 1'b1;

    localparam logic [CP_BITS-1:0] CP_MAX     = 21'h10FFFF;
    localparam logic [CP_BITS-1:0] SURR_FIRST = 21'h00D800;
    localparam logic [CP_BITS-1:0] SURR_LAST  = 21'h00DFFF;
    localparam logic [CP_BITS-1:0] MIN_LEN2   = 21'h000080;
    localparam logic [CP_BITS-1:0] MIN_LEN3   = 21'h000800;
    localparam logic [CP_BITS-1:0] MIN_LEN4   = 21'h010000;

    typedef struct packed {
        logic [FIELD_BITS-1:0] target_offset;
        logic                  opcode;
        logic                  last_of_text;
        logic                  first_of_text;
        logic [7:0]            data_byte;
    } item_t;

    typedef struct packed {
        logic                  found;
        logic [FIELD_BITS-1:0] mapped_offset;
    } result_t;

    function automatic logic [CP_BITS-1:0] min_code_point(input logic [2:0] len);
        logic [CP_BITS-1:0] m;
        case (len)
            3'd2:    m = MIN_LEN2;
            3'd3:    m = MIN_LEN3;
            3'd4:    m = MIN_LEN4;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/core/ouc_in_reg.sv
// Input register of the offset converter: holds one accepted byte transfer.
// Depends on ouc_pkg for the item type.
`timescale 1ns / 1ps

module ouc_in_reg
    import ouc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  item_valid,
    output item_t item,
    input  logic  item_take
);

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;

    assign in_ready   = !vld_reg || item_take;
    assign item_valid = vld_reg;
    assign item       = item_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_ready)
        begin
            vld_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

FILE: rtl/core/ouc_step.sv
// Decoder and counters of the offset converter: one byte per cycle while fire is high.
// Depends on ouc_pkg for the item and result types and the code point limits.
`timescale 1ns / 1ps

module ouc_step
    import ouc_pkg::*;
#(
    parameter int OFFSET_BITS = 20
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    output logic    res_valid,
    output result_t res
);

    localparam int CW = OFFSET_BITS + 1;

    logic [CW-1:0]          byte_cnt_reg, byte_cnt_next;
    logic [CW-1:0]          unit_cnt_reg, unit_cnt_next;
    logic [1:0]             cont_left_reg, cont_left_next;
    logic [2:0]             char_len_reg, char_len_next;
    logic [CP_BITS-1:0]     cp_reg, cp_next;
    logic                   resolved_reg, resolved_next;
    logic [OFFSET_BITS-1:0] target_reg, target_next;
    logic                   mode_reg, mode_next;

    logic [OFFSET_BITS+FIELD_BITS-1:0] target_wide;
    logic [CW+FIELD_BITS-1:0]          map_wide;

    always_comb
    begin
        logic          decided;
        logic          ok;
        logic [CW-1:0] value;
        logic [7:0]    b;
        logic [CW-1:0] units;
        logic          bad;

        b              = item.data_byte;
        byte_cnt_next  = byte_cnt_reg;
        unit_cnt_next  = unit_cnt_reg;
        cont_left_next = cont_left_reg;
        char_len_next  = char_len_reg;
        cp_next        = cp_reg;
        resolved_next  = resolved_reg;
        target_next    = target_reg;
        mode_next      = mode_reg;
        decided        = 1'b0;
        ok             = 1'b0;
        value          = '0;
        units          = '0;
        bad            = 1'b0;
        target_wide    = {{OFFSET_BITS{1'b0}}, item.target_offset};

        if (item.first_of_text)
        begin
            mode_next      = item.opcode;
            target_next    = target_wide[OFFSET_BITS-1:0];
            byte_cnt_next  = '0;
            unit_cnt_next  = '0;
            cont_left_next = 2'd0;
            char_len_next  = 3'd0;
            cp_next        = '0;
            resolved_next  = 1'b0;
            if (target_next == '0)
            begin
                decided = 1'b1;
                ok      = 1'b1;
            end
        end

        if (!decided && !resolved_next)
        begin
            if (cont_left_next == 2'd0)
            begin
                if (b[7] == 1'b0)
                begin
                    char_len_next = 3'd1;
                    cp_next       = {13'd0, b};
                end
                else if (b[7:5] == 3'b110)
                begin
                    char_len_next = 3'd2;
                    cp_next       = {16'd0, b[4:0]};
                end
                else if (b[7:4] == 4'b1110)
                begin
                    char_len_next = 3'd3;
                    cp_next       = {17'd0, b[3:0]};
                end
                else if (b[7:3] == 5'b11110)
                begin
                    char_len_next = 3'd4;
                    cp_next       = {18'd0, b[2:0]};
                end
                else
                begin
                    bad = 1'b1;
                end
                if (bad)
                begin
                    decided = 1'b1;
                end
                else
                begin
                    cont_left_next = 2'(char_len_next - 3'd1);
                    units = (char_len_next == 3'd4) ? CW'(2) : CW'(1);
                    if (mode_next == OPC_UNITS_TO_BYTES)
                    begin
                        if (unit_cnt_next + units > {1'b0, target_next})
                        begin
                            decided = 1'b1;
                        end
                    end
                    else
                    begin
                        if (byte_cnt_next + CW'(char_len_next) > {1'b0, target_next})
                        begin
                            decided = 1'b1;
                        end
                    end
                end
            end
            else
            begin
                if (b[7:6] != 2'b10)
                begin
                    decided = 1'b1;
                end
                else
                begin
                    cp_next        = {cp_next[CP_BITS-7:0], b[5:0]};
                    cont_left_next = cont_left_next - 2'd1;
                end
            end

            if (!decided && cont_left_next == 2'd0)
            begin
                units = (char_len_next == 3'd4) ? CW'(2) : CW'(1);
                if (char_len_next > 3'd4 || cp_next < min_code_point(char_len_next)
                    || cp_next > CP_MAX || (cp_next >= SURR_FIRST && cp_next <= SURR_LAST))
                begin
                    decided = 1'b1;
                end
                else
                begin
                    byte_cnt_next = byte_cnt_next + CW'(char_len_next);
                    unit_cnt_next = unit_cnt_next + units;
                    if (byte_cnt_next[OFFSET_BITS])
                    begin
                        decided = 1'b1;
                    end
                    else if (mode_next == OPC_UNITS_TO_BYTES)
                    begin
                        if (unit_cnt_next == {1'b0, target_next})
                        begin
                            decided = 1'b1;
                            ok      = 1'b1;
                            value   = byte_cnt_next;
                        end
                    end
                    else
                    begin
                        if (byte_cnt_next == {1'b0, target_next})
                        begin
                            decided = 1'b1;
                            ok      = 1'b1;
                            value   = unit_cnt_next;
                        end
                    end
                end
            end

            if (!decided && item.last_of_text)
            begin
                decided = 1'b1;
            end
        end

        if (decided)
        begin
            resolved_next = 1'b1;
        end

        map_wide      = {{FIELD_BITS{1'b0}}, value};
        res_valid     = fire && decided;
        res.found     = ok;
        res.mapped_offset = ok ? map_wide[FIELD_BITS-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg  <= '0;
            unit_cnt_reg  <= '0;
            cont_left_reg <= 2'd0;
            char_len_reg  <= 3'd0;
            cp_reg        <= '0;
            resolved_reg  <= 1'b1;
            target_reg    <= '0;
            mode_reg      <= 1'b0;
        end
        else if (fire)
        begin
            byte_cnt_reg  <= byte_cnt_next;
            unit_cnt_reg  <= unit_cnt_next;
            cont_left_reg <= cont_left_next;
            char_len_reg  <= char_len_next;
            cp_reg        <= cp_next;
            resolved_reg  <= resolved_next;
            target_reg    <= target_next;
            mode_reg      <= mode_next;
        end
    end

endmodule

FILE: rtl/core/ouc_out_reg.sv
// Result register of the offset converter: holds one result until taken.
// Depends on ouc_pkg for the result type.
`timescale 1ns / 1ps

module ouc_out_reg
    import ouc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_res,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;

    assign out_valid = vld_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

endmodule

FILE: rtl/core/utf8_utf16_offset_converter_core.sv
// Top level of the UTF-8 to UTF-16 offset converter.
// Depends on ouc_pkg, ouc_in_reg, ouc_step and ouc_out_reg.
`timescale 1ns / 1ps

// The slave channel carries the text one byte per transfer, with the query
// opcode and target offset sampled on the transfer that has first_of_text set.
// tlast marks the final byte of the text. The master channel returns one
// result per query: found in tuser and the mapped offset in tdata.
// A byte is registered on acceptance and decoded once the result register is free;
// the deciding byte's result then goes through the result register to the master side.
// One byte is accepted every cycle unless a result is stalled; the rate is set
// by the single decode step that updates the byte and unit counters for each byte.
// Bytes outside an open query are dropped without a result.
// Reset empties both registers and leaves no query open.
// When the receiver stalls, the waiting result holds, one more byte can enter
// the input register, and s_tready then falls until the result is taken.

module utf8_utf16_offset_converter_core
    import ouc_pkg::*;
#(
    parameter int OFFSET_BITS = 20
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // data_byte, target_offset, zero fill
    input  logic                 s_tlast,
    input  logic [S_TUSER_W-1:0] s_tuser,   // first_of_text, opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // mapped_offset, zero fill
    output logic [M_TUSER_W-1:0] m_tuser    // found
);

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    fire;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign in_item.data_byte     = s_tdata[7:0];
    assign in_item.target_offset = s_tdata[8+FIELD_BITS-1:8];
    assign in_item.first_of_text = s_tuser[0];
    assign in_item.opcode        = s_tuser[1];
    assign in_item.last_of_text  = s_tlast;

    assign fire = item_valid && (!m_tvalid || m_tready);

    ouc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (fire)
    );

    ouc_step #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    ouc_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_res  (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {{(M_TDATA_W-FIELD_BITS){1'b0}}, out_res.mapped_offset};
    assign m_tuser = out_res.found;

`ifndef NO_ASSERTIONS
    a_no_step_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !fire)
        else $error("decode step ran while a result was stalled");

    a_result_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> m_tvalid)
        else $error("decided query did not reach the result register");

    a_failure_has_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !out_res.found) |-> (out_res.mapped_offset == '0))
        else $error("failed query carries a nonzero offset");
`endif

endmodule
